### rtl/tsswt_pkg.sv
// Package: shared types and constants for the task slot sleep/wakeup table.
package tsswt_pkg;

  // Table geometry
  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths
  localparam int PERIOD_W = 16;
  localparam int TICK_W   = 32;
  localparam int PRIO_W   = 8;
  localparam int MASK_W   = 16;
  localparam int DIV_CNT_W = $clog2(TICK_W);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(10);

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_SLEEP  = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_EXIT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_FREE  = 2'd1,
    STATUS_BAD_SLOT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADD,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [3:0]        task_slot;
    logic [PRIO_W-1:0] priority_req;
    logic [TICK_W-1:0] sleep_ms;
    logic [TICK_W-1:0] now_tick;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [3:0]        alloc_slot;
    logic [MASK_W-1:0] woken_mask;
    logic [TICK_W-1:0] wake_deadline;
  } out_word_t;

endpackage

### rtl/task_slot_sleep_wakeup_table.sv
// Top level: task slot table with create, sleep, tick wakeup and exit items.
//
// Usage:
//   Input words (in_word) are taken when in_valid is high and in_stall is
//   low; one result word comes back on out_word for every input word, in
//   order, under out_valid / out_stall. cfg_we with cfg_data sets the tick
//   period in milliseconds (zero acts as one); write it only while idle.
// Steps (from accept to the raising of out_valid, no stall):
//   create / exit, sleep on a bad slot: the output register is loaded.
//   sleep: a shared bit-serial divider takes one quotient bit
//     per cycle (32 steps), then comes the deadline add, and then the
//     output register is loaded.
//   tick: one shared deadline comparator visits one slot per
//     cycle from slot 1 upward, then the output register is loaded.
// Throughput: one word at a time; in_stall stays high from accept until
//   the result has moved into the output register.
// Reset (rst, synchronous): all slots free and ready, tick period 10 ms,
//   no result pending. When the receiver stalls, the result word holds in
//   the output register and the next input word may already be taken; its
//   own result waits in the sequencer until the register frees.
module task_slot_sleep_wakeup_table
  import tsswt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_word_t            in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_word,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [PERIOD_W-1:0] tick_period_ms;
  logic [SLOTS-1:0]    slot_used;
  logic [SLOTS-1:0]    slot_sleeping;
  logic [PRIO_W-1:0]   slot_priority [SLOTS];
  logic [TICK_W-1:0]   slot_counter  [SLOTS];

  in_word_t            item;
  out_word_t           res;
  out_word_t           res_first;
  logic [PERIOD_W-1:0] rem;
  logic [TICK_W-1:0]   quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SLOT_W-1:0]   scan_idx;

  logic                in_accept;
  logic                out_free;
  logic [SLOT_W-1:0]   in_slot;
  logic                in_slot_ok;
  logic                free_found;
  logic [SLOT_W-1:0]   free_idx;
  logic [PERIOD_W-1:0] divisor;
  logic [PERIOD_W:0]   rem_sh;
  logic                div_fit;
  logic                div_last;
  logic                scan_last;
  logic                wake_hit;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // Slot addressed by sleep / exit
  assign in_slot    = SLOT_W'(in_word.task_slot);
  assign in_slot_ok = (32'(in_word.task_slot) < SLOTS) && slot_used[in_slot];

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Result fields known at accept
  always_comb begin
    res_first = '{status: STATUS_OK, alloc_slot: '0, woken_mask: '0,
                  wake_deadline: '0};
    case (in_word.kind)
      KIND_CREATE: begin
        if (free_found) begin
          res_first.alloc_slot = 4'(free_idx);
        end else begin
          res_first.status = STATUS_NO_FREE;
        end
      end
      KIND_SLEEP: if (!in_slot_ok) res_first.status = STATUS_BAD_SLOT;
      KIND_EXIT:  if (!(in_slot_ok && in_slot != '0)) res_first.status = STATUS_BAD_SLOT;
      default: ;
    endcase
  end

  // Shared divider step: one restoring step per cycle
  assign divisor  = (tick_period_ms == '0) ? PERIOD_W'(1) : tick_period_ms;
  assign rem_sh   = {rem, quo[TICK_W-1]};
  assign div_fit  = rem_sh >= {1'b0, divisor};
  assign div_last = (div_cnt == '0);

  // Shared deadline comparator for the tick scan
  assign scan_last = (32'(scan_idx) == SLOTS - 1);
  assign wake_hit  = slot_used[scan_idx] && slot_sleeping[scan_idx] &&
                     (item.now_tick >= slot_counter[scan_idx]);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_word.kind)
            KIND_SLEEP: state_next = in_slot_ok ? ST_DIV : ST_DONE;
            KIND_TICK:  state_next = ST_SCAN;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_DIV:  if (div_last) state_next = ST_ADD;
      ST_ADD:  state_next = ST_DONE;
      ST_SCAN: if (scan_last) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state: config register, slot flags, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_ms <= PERIOD_RESET;
      slot_used      <= '0;
      slot_sleeping  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        tick_period_ms <= cfg_data;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_word.kind == KIND_CREATE && free_found) begin
              slot_used[free_idx]     <= 1'b1;
              slot_sleeping[free_idx] <= 1'b0;
            end else if (in_word.kind == KIND_EXIT && in_slot_ok && in_slot != '0) begin
              slot_used[in_slot]     <= 1'b0;
              slot_sleeping[in_slot] <= 1'b0;
            end
          end
        end
        ST_ADD:  slot_sleeping[SLOT_W'(item.task_slot)] <= 1'b1;
        ST_SCAN: if (wake_hit) slot_sleeping[scan_idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  // Datapath: item, divider, scan, slot payload, result
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_word <= res;
    end
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          item     <= in_word;
          rem      <= '0;
          quo      <= in_word.sleep_ms;
          div_cnt  <= DIV_CNT_W'(TICK_W - 1);
          scan_idx <= SLOT_W'(1);
          res      <= res_first;
          if (in_word.kind == KIND_CREATE && free_found) begin
            slot_priority[free_idx] <= in_word.priority_req;
            slot_counter[free_idx]  <= TICK_W'(in_word.priority_req);
          end
        end
      end
      ST_DIV: begin
        rem     <= div_fit ? PERIOD_W'(rem_sh - {1'b0, divisor}) : rem_sh[PERIOD_W-1:0];
        quo     <= {quo[TICK_W-2:0], div_fit};
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
      ST_ADD: begin
        // deadline = now + ceil(ms / period), wrapping
        slot_counter[SLOT_W'(item.task_slot)] <=
          item.now_tick + quo + TICK_W'(rem != '0);
        res.wake_deadline <= item.now_tick + quo + TICK_W'(rem != '0);
      end
      ST_SCAN: begin
        if (wake_hit) begin
          slot_counter[scan_idx] <= TICK_W'(slot_priority[scan_idx]);
          res.woken_mask         <= res.woken_mask | (MASK_W'(1) << scan_idx);
        end
        scan_idx <= scan_idx + SLOT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

### sim/tsswt_checker.sv
// Checker for the task slot table: mirrors slot state, predicts each result word and compares.
`timescale 1ns / 100ps

module tsswt_checker
  import tsswt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_word_t            in_word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_word_t           out_word,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending
);

  // Shadow copy of the slot table and the tick period
  logic                slot_in_use [SLOTS];
  logic                slot_asleep [SLOTS];
  logic [PRIO_W-1:0]   slot_prio   [SLOTS];
  logic [TICK_W-1:0]   slot_count  [SLOTS];
  logic [PERIOD_W-1:0] period_ms;

  // Result words still owed by the block, oldest first
  out_word_t awaited_words [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    period_ms  = PERIOD_RESET;
  end

  // Apply one input word to the shadow table and return the result word it causes
  function automatic out_word_t apply_word(input in_word_t w);
    out_word_t         r;
    logic [TICK_W-1:0] divisor;
    logic [TICK_W-1:0] ticks;
    r = '0;
    r.status = STATUS_OK;
    case (w.kind)
      KIND_CREATE: begin
        // lowest free slot wins; full table leaves everything alone
        r.status = STATUS_NO_FREE;
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_in_use[i] && r.status == STATUS_NO_FREE) begin
            slot_in_use[i] = 1'b1;
            slot_asleep[i] = 1'b0;
            slot_prio[i]   = w.priority_req;
            slot_count[i]  = TICK_W'(w.priority_req);
            r.status       = STATUS_OK;
            r.alloc_slot   = 4'(i);
          end
        end
      end
      KIND_SLEEP: begin
        if (slot_in_use[w.task_slot]) begin
          // ceiling division; a zero period acts as one
          divisor = (period_ms == '0) ? TICK_W'(1) : TICK_W'(period_ms);
          ticks   = w.sleep_ms / divisor;
          if (w.sleep_ms % divisor != '0) ticks = ticks + 1;
          slot_count[w.task_slot]  = w.now_tick + ticks;
          slot_asleep[w.task_slot] = 1'b1;
          r.wake_deadline          = w.now_tick + ticks;
        end else begin
          r.status = STATUS_BAD_SLOT;
        end
      end
      KIND_TICK: begin
        // slot 0 is never woken
        for (int i = 1; i < SLOTS; i++) begin
          if (slot_in_use[i] && slot_asleep[i] && w.now_tick >= slot_count[i]) begin
            slot_asleep[i] = 1'b0;
            slot_count[i]  = TICK_W'(slot_prio[i]);
            if (i < MASK_W) r.woken_mask[i] = 1'b1;
          end
        end
      end
      default: begin
        if (w.task_slot != '0 && slot_in_use[w.task_slot]) begin
          slot_in_use[w.task_slot] = 1'b0;
          slot_asleep[w.task_slot] = 1'b0;
        end else begin
          r.status = STATUS_BAD_SLOT;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Watch both channels and the config port at every rising edge
  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_in_use[i] = 1'b0;
        slot_asleep[i] = 1'b0;
        slot_prio[i]   = '0;
        slot_count[i]  = '0;
      end
      period_ms = PERIOD_RESET;
      awaited_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_words.size() == 0) begin
          $error("result word %h arrived with none outstanding", out_word);
          fail_count++;
        end else begin
          want = awaited_words.pop_front();
          check_field("status", 32'(want.status), 32'(out_word.status));
          check_field("alloc_slot", 32'(want.alloc_slot), 32'(out_word.alloc_slot));
          check_field("woken_mask", 32'(want.woken_mask), 32'(out_word.woken_mask));
          check_field("wake_deadline", want.wake_deadline, out_word.wake_deadline);
        end
      end
      if (in_valid && !in_stall) awaited_words.push_back(apply_word(in_word));
      if (cfg_we) period_ms = cfg_data;
    end
    pending = awaited_words.size();
  end

endmodule

### sim/tb_top.sv
// Testbench top: drives the task slot table with directed and random words, gives the verdict.
`timescale 1ns / 100ps

module tb_top;
  import tsswt_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 330;
  localparam int CALM_WORDS  = 200;
  localparam int SQUEEZE_AT  = 400;
  localparam int SQUEEZE_LEN = 300;
  localparam int STALL_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  in_word_t            in_word;
  logic                out_valid;
  logic                out_stall;
  out_word_t           out_word;
  logic                cfg_we;
  logic [PERIOD_W-1:0] cfg_data;

  int                  fail_count;
  int                  pending;
  int                  sent_count;
  bit                  calm;
  logic [TICK_W-1:0]   sys_tick;
  logic [PERIOD_W-1:0] cur_period;

  always #4 clk = ~clk;

  task_slot_sleep_wakeup_table DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  tsswt_checker scoreboard (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog: too long without any word moving ends the run
  always @(posedge clk) begin : watchdog
    int dry_cycles;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      dry_cycles = 0;
    end else begin
      dry_cycles++;
      if (dry_cycles >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off to back the block up
  initial begin : receiver
    int  hold;
    bit  squeezed;
    out_stall = 1'b0;
    hold      = 0;
    squeezed  = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_stall <= 1'b0;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if (!squeezed && sent_count >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        out_stall <= 1'b1;
        hold = SQUEEZE_LEN;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        hold = $urandom_range(0, 9);
      end else begin
        out_stall <= 1'b0;
        hold = $urandom_range(0, 29);
      end
    end
  end

  function automatic in_word_t make_word(input kind_t k, input logic [3:0] slot,
                                         input logic [PRIO_W-1:0] prio,
                                         input logic [TICK_W-1:0] ms,
                                         input logic [TICK_W-1:0] now);
    in_word_t w;
    w.kind         = k;
    w.task_slot    = slot;
    w.priority_req = prio;
    w.sleep_ms     = ms;
    w.now_tick     = now;
    return w;
  endfunction

  // Mostly plausible kernel traffic around a running tick; some pure noise
  function automatic in_word_t random_word();
    in_word_t          w;
    logic [TICK_W-1:0] p;
    int                pick;
    p = (cur_period == '0) ? TICK_W'(1) : TICK_W'(cur_period);
    w = make_word(KIND_CREATE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                  $urandom, $urandom);
    if ($urandom_range(0, 49) == 0) sys_tick = sys_tick + $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      w.kind = KIND_CREATE;
    end else if (pick < 60) begin
      w.kind = KIND_SLEEP;
      if ($urandom_range(0, 9) != 0) begin
        w.sleep_ms = p * $urandom_range(0, 12);
        if ($urandom_range(0, 1) == 1) w.sleep_ms = w.sleep_ms + $urandom_range(0, p - 1);
        w.now_tick = sys_tick;
      end
    end else if (pick < 85) begin
      w.kind = KIND_TICK;
      sys_tick = sys_tick + $urandom_range(0, 4);
      if ($urandom_range(0, 9) != 0) w.now_tick = sys_tick;
    end else begin
      w.kind = KIND_EXIT;
    end
    return w;
  endfunction

  // Offer one word and hold it until taken
  task automatic send_word(input in_word_t w);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    sent_count++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every result word is back
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
    cur_period = value;
  endtask

  initial begin : stimulus
    logic [PERIOD_W-1:0] plan [PHASES];
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_word    = '0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    calm       = 1'b0;
    sent_count = 0;
    cur_period = PERIOD_RESET;
    sys_tick   = $urandom;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: fill the table, overflow it, then the odd sleep and exit cases
    send_word(make_word(KIND_CREATE, 4'd0, 8'd0, '0, '0));
    send_word(make_word(KIND_CREATE, 4'd0, 8'hFF, '0, '0));
    for (int i = 2; i < SLOTS; i++)
      send_word(make_word(KIND_CREATE, 4'd0, 8'($urandom_range(0, 255)), '0, '0));
    send_word(make_word(KIND_CREATE, 4'd0, 8'd7, '0, '0));
    send_word(make_word(KIND_SLEEP, 4'd0, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(KIND_SLEEP, 4'd1, 8'd0, 32'd0, 32'd5));
    send_word(make_word(KIND_SLEEP, 4'd1, 8'd0, 32'd25, 32'd100));
    send_word(make_word(KIND_TICK, 4'd0, 8'd0, '0, 32'd103));
    send_word(make_word(KIND_EXIT, 4'd0, 8'd0, '0, '0));
    send_word(make_word(KIND_EXIT, 4'd2, 8'd0, '0, '0));
    send_word(make_word(KIND_EXIT, 4'd2, 8'd0, '0, '0));
    send_word(make_word(KIND_SLEEP, 4'd2, 8'd0, 32'd40, 32'd0));
    settle();

    // Random phases, each under its own tick period
    plan[0] = 16'd1;
    plan[1] = 16'hFFFF;
    plan[2] = 16'd0;
    plan[3] = 16'($urandom_range(2, 100));
    plan[4] = 16'($urandom_range(1, 65535));
    plan[5] = PERIOD_RESET;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_period(plan[ph]);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (ph == PHASES - 1 && k >= PHASE_WORDS - CALM_WORDS) calm = 1'b1;
        send_word(random_word());
      end
      settle();
    end

    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/tsswt_pkg.sv
rtl/task_slot_sleep_wakeup_table.sv
sim/tsswt_checker.sv
sim/tb_top.sv
